FILE: hdl/srtf_pkg.sv
// Shared types, widths and codes of the shortest-remaining-time tick scheduler.
`timescale 1ns / 1ps

package srtf_pkg;

  // Default sizes handed to the top level.
  localparam int MAX_JOBS_DEF  = 16;
  localparam int TIME_BITS_DEF = 16;

  // Fixed field widths.
  localparam int FUNC_W = 2;
  localparam int SLOT_W = 4;
  localparam int KIND_W = 3;
  localparam int VAL_W  = 16;
  localparam int TURN_W = 17;
  localparam int JC_W   = 5;
  localparam int CFG_IDX_W = 1;

  // Input function codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REPORT  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

  // Event kinds.
  localparam logic [KIND_W-1:0] EV_ARRIVED  = 3'd0;
  localparam logic [KIND_W-1:0] EV_FINISHED = 3'd1;
  localparam logic [KIND_W-1:0] EV_SELECTED = 3'd2;
  localparam logic [KIND_W-1:0] EV_IDLE     = 3'd3;
  localparam logic [KIND_W-1:0] EV_END      = 3'd4;
  localparam logic [KIND_W-1:0] EV_REPORT   = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_JOB_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT = 1'b1;

  // Saturation value of the wait and run counters.
  localparam logic [VAL_W-1:0] CNT_MAX = 16'hFFFF;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  ev_time;
    logic [VAL_W-1:0]  value;
    logic [TURN_W-1:0] turnaround;
  } event_t;

  // Sequencer request to the output stage.
  typedef struct packed {
    logic   req;
    logic   flush;
    event_t ev;
  } emit_t;

  // Output stage status back to the sequencer.
  typedef struct packed {
    logic stall;
    logic flush_ok;
  } oq_stat_t;

endpackage

FILE: hdl/srtf_tick_scheduler.sv
// Top level of the shortest-remaining-time-first tick scheduler.
//
// Use: items enter on the in_ stream. in_tuser selects the function: load a
// slot (arrival tick and burst), advance the schedule by one tick, or report
// one slot's wait and turnaround. Results leave on the out_ stream with the
// event kind in out_tuser; out_tlast marks the last beat caused by one item.
// Loads and ignored functions give no beat; an advance that changes nothing
// visible gives none either. The cfg_ channel writes job_count and
// time_limit; the user must do so only while the block is idle, since
// the block itself does not enforce it. All per-slot records sit in one
// single-port-read memory, so the scan and wait passes each read one slot
// per access. in_tready is low while an item is in work. Reset clears the
// flags, the tick and the running job; records stay undefined until loaded,
// except that wait and run counts report as zero. A stalled receiver holds
// the output register and, once one more event is pending, halts the
// sequencer until beats drain.
`timescale 1ns / 1ps

module srtf_tick_scheduler #(
  parameter int MAX_JOBS  = srtf_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // slot[3:0], arrival_time[19:4], burst_len[35:20]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // event_slot[3:0], event_time[19:4], event_value[35:20],
                                  // turnaround[52:36]
  output logic [2:0]  out_tuser,  // event_kind[2:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [srtf_pkg::JC_W-1:0]  job_count_r;
  logic [srtf_pkg::VAL_W-1:0] time_limit_r;
  srtf_pkg::emit_t            emit;
  srtf_pkg::oq_stat_t         oq_stat;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_count_r  <= srtf_pkg::JC_W'(1);
      time_limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srtf_pkg::CFG_JOB_COUNT:  job_count_r  <= cfg_data[srtf_pkg::JC_W-1:0];
        srtf_pkg::CFG_TIME_LIMIT: time_limit_r <= cfg_data;
      endcase
    end
  end

  srtf_seq #(
    .MAX_JOBS  (MAX_JOBS),
    .TIME_BITS (TIME_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_func    (in_tuser),
    .in_slot    (in_tdata[3:0]),
    .in_arrive  (in_tdata[19:4]),
    .in_burst   (in_tdata[35:20]),
    .job_count  (job_count_r),
    .time_limit (time_limit_r),
    .emit       (emit),
    .oq_stat    (oq_stat)
  );

  srtf_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .stat       (oq_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: hdl/srtf_alu.sv
// Shared compare and counter unit of the scheduler.
`timescale 1ns / 1ps

module srtf_alu (
  input  logic [srtf_pkg::VAL_W-1:0] a_i,
  input  logic [srtf_pkg::VAL_W-1:0] b_i,
  output logic                       a_lt_b,
  output logic                       a_le_b,
  output logic                       a_zero,
  output logic [srtf_pkg::VAL_W-1:0] a_dec,
  output logic [srtf_pkg::VAL_W-1:0] b_inc
);

  // Comparisons used by selection and finish checks.
  assign a_lt_b = a_i < b_i;
  assign a_le_b = a_i <= b_i;
  assign a_zero = a_i == '0;

  // Burst countdown and saturating tick counters.
  assign a_dec = a_i - srtf_pkg::VAL_W'(1);
  assign b_inc = (b_i == srtf_pkg::CNT_MAX) ? b_i : b_i + srtf_pkg::VAL_W'(1);

endmodule

FILE: hdl/srtf_mem.sv
// Per-slot record memory: arrival tick, remaining burst, wait and run counts.
`timescale 1ns / 1ps

module srtf_mem #(
  parameter int MAX_JOBS  = srtf_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [$clog2(MAX_JOBS)-1:0]         rd_addr,
  input  logic                                wr_en,
  input  logic [$clog2(MAX_JOBS)-1:0]         wr_addr,
  input  logic [TIME_BITS-1:0]                wr_arrive,
  input  logic [srtf_pkg::VAL_W-1:0]          wr_rem,
  input  logic [srtf_pkg::VAL_W-1:0]          wr_wait,
  input  logic [srtf_pkg::VAL_W-1:0]          wr_run,
  output logic [TIME_BITS-1:0]                rd_arrive,
  output logic [srtf_pkg::VAL_W-1:0]          rd_rem,
  output logic [srtf_pkg::VAL_W-1:0]          rd_wait,
  output logic [srtf_pkg::VAL_W-1:0]          rd_run
);

  localparam int VW    = srtf_pkg::VAL_W;
  localparam int REC_W = TIME_BITS + 3 * VW;

  logic [REC_W-1:0] rec_mem [MAX_JOBS];
  logic [REC_W-1:0] rd_data_r;

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rec_mem[wr_addr] <= {wr_arrive, wr_rem, wr_wait, wr_run};
    end
    if (rd_en) begin
      rd_data_r <= rec_mem[rd_addr];
    end
  end

  assign rd_run    = rd_data_r[VW-1:0];
  assign rd_wait   = rd_data_r[2*VW-1:VW];
  assign rd_rem    = rd_data_r[3*VW-1:2*VW];
  assign rd_arrive = rd_data_r[REC_W-1:3*VW];

endmodule

FILE: hdl/srtf_outq.sv
// Output stage: one pending event plus the output register, marks the last beat.
`timescale 1ns / 1ps

module srtf_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srtf_pkg::emit_t      emit,
  output srtf_pkg::oq_stat_t   stat,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [55:0]          out_tdata,
  output logic [2:0]           out_tuser,
  output logic                 out_tlast
);

  logic               pend_vld_r;
  srtf_pkg::event_t   pend_r;
  logic               out_vld_r;
  srtf_pkg::event_t   out_ev_r;
  logic               out_last_r;
  logic               push_ok;
  logic               take;
  logic               push;

  // The pending event moves out once it is known whether another follows.
  assign push_ok       = !out_vld_r || out_tready;
  assign stat.stall    = emit.req && pend_vld_r && !push_ok;
  assign stat.flush_ok = !pend_vld_r || push_ok;
  assign take          = emit.req && !stat.stall;
  assign push          = (take && pend_vld_r) || (emit.flush && pend_vld_r && push_ok);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (take) begin
        pend_vld_r <= 1'b1;
      end else if (emit.flush && push_ok) begin
        pend_vld_r <= 1'b0;
      end
      if (push) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (push) begin
      out_ev_r   <= pend_r;
      out_last_r <= emit.flush;
    end
    if (take) begin
      pend_r <= emit.ev;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ev_r.kind;
  assign out_tdata  = {3'b000, out_ev_r.turnaround, out_ev_r.value,
                       out_ev_r.ev_time, out_ev_r.slot};

endmodule

FILE: hdl/srtf_seq.sv
// Sequencer: serves reports and walks the slot table through finish, arrival, selection, run and wait steps.
`timescale 1ns / 1ps

module srtf_seq #(
  parameter int MAX_JOBS  = srtf_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [srtf_pkg::FUNC_W-1:0]   in_func,
  input  logic [srtf_pkg::SLOT_W-1:0]   in_slot,
  input  logic [srtf_pkg::VAL_W-1:0]    in_arrive,
  input  logic [srtf_pkg::VAL_W-1:0]    in_burst,
  input  logic [srtf_pkg::JC_W-1:0]     job_count,
  input  logic [srtf_pkg::VAL_W-1:0]    time_limit,
  output srtf_pkg::emit_t               emit,
  input  srtf_pkg::oq_stat_t            oq_stat
);

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int VW    = srtf_pkg::VAL_W;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_REP_RD  = 4'd1;
  localparam logic [3:0] ST_REP_EV  = 4'd2;
  localparam logic [3:0] ST_FIN_RD  = 4'd3;
  localparam logic [3:0] ST_FIN_EV  = 4'd4;
  localparam logic [3:0] ST_SCAN_RD = 4'd5;
  localparam logic [3:0] ST_SCAN_EV = 4'd6;
  localparam logic [3:0] ST_SEL     = 4'd7;
  localparam logic [3:0] ST_RUN_RD  = 4'd8;
  localparam logic [3:0] ST_RUN_WR  = 4'd9;
  localparam logic [3:0] ST_WAIT_RD = 4'd10;
  localparam logic [3:0] ST_WAIT_WR = 4'd11;
  localparam logic [3:0] ST_END     = 4'd12;
  localparam logic [3:0] ST_FLUSH   = 4'd13;

  logic [3:0]                  state_r;
  logic [3:0]                  state_nxt;
  logic [IDX_W-1:0]            idx_r;
  logic [IDX_W-1:0]            cur_r;
  logic [IDX_W-1:0]            best_r;
  logic [VW-1:0]               best_rem_r;
  logic [VW-1:0]               cur_rem_r;
  logic                        best_vld_r;
  logic                        running_r;
  logic [TIME_BITS-1:0]        now_r;
  logic [MAX_JOBS-1:0]         arrived_r;
  logic [MAX_JOBS-1:0]         done_r;
  logic [MAX_JOBS-1:0]         loaded_r;
  logic [srtf_pkg::SLOT_W-1:0] slot_r;

  logic                        acc;
  logic                        slot_ok;
  logic [IDX_W-1:0]            slot_idx;
  logic                        rep_ok;
  logic [IDX_W-1:0]            rep_idx;
  logic [CNT_W-1:0]            n_w;
  logic                        idx_last;
  logic [TIME_BITS-1:0]        lim;
  logic                        stall;
  logic                        fin_hit;
  logic                        arr_hit;
  logic                        cand;
  logic                        take_best;
  logic                        sel_switch;
  logic                        elig;
  logic                        end_hit;
  logic                        idle_hit;
  logic                        run_go;
  logic [VW-1:0]               rep_w;
  logic [VW-1:0]               rep_r;

  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [TIME_BITS-1:0]        wr_arrive;
  logic [VW-1:0]               wr_rem;
  logic [VW-1:0]               wr_wait;
  logic [VW-1:0]               wr_run;
  logic [TIME_BITS-1:0]        rd_arrive;
  logic [VW-1:0]               rd_rem;
  logic [VW-1:0]               rd_wait;
  logic [VW-1:0]               rd_run;

  logic [VW-1:0]               alu_a;
  logic [VW-1:0]               alu_b;
  logic                        alu_lt;
  logic                        alu_le;
  logic                        alu_zero;
  logic [VW-1:0]               alu_dec;
  logic [VW-1:0]               alu_inc;

  srtf_mem #(
    .MAX_JOBS  (MAX_JOBS),
    .TIME_BITS (TIME_BITS)
  ) u_mem (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_arrive (wr_arrive),
    .wr_rem    (wr_rem),
    .wr_wait   (wr_wait),
    .wr_run    (wr_run),
    .rd_arrive (rd_arrive),
    .rd_rem    (rd_rem),
    .rd_wait   (rd_wait),
    .rd_run    (rd_run)
  );

  srtf_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .a_lt_b (alu_lt),
    .a_le_b (alu_le),
    .a_zero (alu_zero),
    .a_dec  (alu_dec),
    .b_inc  (alu_inc)
  );

  // Decode of the current step.
  assign in_ready = state_r == ST_IDLE;
  assign acc      = in_valid && in_ready;
  assign slot_ok  = 32'(in_slot) < MAX_JOBS;
  assign slot_idx = IDX_W'(in_slot);
  assign rep_ok   = 32'(slot_r) < MAX_JOBS;
  assign rep_idx  = IDX_W'(slot_r);
  assign lim      = TIME_BITS'(time_limit);
  assign stall    = oq_stat.stall;

  always_comb begin
    if (32'(job_count) > MAX_JOBS) begin
      n_w = CNT_W'(MAX_JOBS);
    end else begin
      n_w = CNT_W'(job_count);
    end
  end

  assign idx_last   = (CNT_W'(idx_r) + CNT_W'(1)) == n_w;
  assign fin_hit    = alu_zero && !done_r[cur_r];
  assign arr_hit    = !arrived_r[idx_r] && (rd_arrive == now_r);
  assign cand       = (arrived_r[idx_r] || arr_hit) && !done_r[idx_r];
  assign take_best  = cand && (!best_vld_r || alu_lt);
  assign sel_switch = best_vld_r && !(running_r && alu_le);
  assign elig       = arrived_r[idx_r] && !done_r[idx_r] && !(running_r && idx_r == cur_r);
  assign end_hit    = now_r == lim;
  assign idle_hit   = (now_r < lim) && !running_r;
  assign run_go     = running_r && (cur_rem_r != '0);
  assign rep_w      = (rep_ok && loaded_r[rep_idx]) ? rd_wait : '0;
  assign rep_r      = (rep_ok && loaded_r[rep_idx]) ? rd_run : '0;

  // Operand selection for the shared unit.
  always_comb begin
    unique case (state_r)
      ST_SEL: begin
        alu_a = cur_rem_r;
        alu_b = best_rem_r;
      end
      ST_RUN_WR: begin
        alu_a = rd_rem;
        alu_b = rd_run;
      end
      ST_WAIT_WR: begin
        alu_a = rd_rem;
        alu_b = rd_wait;
      end
      default: begin
        alu_a = rd_rem;
        alu_b = best_rem_r;
      end
    endcase
  end

  // Record memory accesses.
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_arrive = rd_arrive;
    wr_rem    = rd_rem;
    wr_wait   = rd_wait;
    wr_run    = rd_run;
    unique case (state_r)
      ST_IDLE: begin
        wr_en     = acc && (in_func == srtf_pkg::FUNC_LOAD) && slot_ok;
        wr_addr   = slot_idx;
        wr_arrive = TIME_BITS'(in_arrive);
        wr_rem    = in_burst;
        wr_wait   = '0;
        wr_run    = '0;
      end
      ST_REP_RD: begin
        rd_en   = 1'b1;
        rd_addr = rep_idx;
      end
      ST_FIN_RD: begin
        rd_en   = running_r;
        rd_addr = cur_r;
      end
      ST_SCAN_RD: begin
        rd_en = 1'b1;
      end
      ST_RUN_RD: begin
        rd_en   = run_go;
        rd_addr = cur_r;
      end
      ST_RUN_WR: begin
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_rem  = alu_dec;
        wr_run  = alu_inc;
      end
      ST_WAIT_RD: begin
        rd_en = elig;
      end
      ST_WAIT_WR: begin
        wr_en   = 1'b1;
        wr_wait = alu_inc;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Events handed to the output stage.
  always_comb begin
    emit               = '0;
    emit.ev.ev_time    = VW'(now_r);
    unique case (state_r)
      ST_REP_EV: begin
        emit.req           = 1'b1;
        emit.ev.kind       = srtf_pkg::EV_REPORT;
        emit.ev.slot       = slot_r;
        emit.ev.value      = rep_w;
        emit.ev.turnaround = srtf_pkg::TURN_W'(rep_w) + srtf_pkg::TURN_W'(rep_r);
      end
      ST_FIN_EV: begin
        emit.req     = fin_hit;
        emit.ev.kind = srtf_pkg::EV_FINISHED;
        emit.ev.slot = srtf_pkg::SLOT_W'(cur_r);
      end
      ST_SCAN_EV: begin
        emit.req     = arr_hit;
        emit.ev.kind = srtf_pkg::EV_ARRIVED;
        emit.ev.slot = srtf_pkg::SLOT_W'(idx_r);
      end
      ST_SEL: begin
        emit.req      = sel_switch;
        emit.ev.kind  = srtf_pkg::EV_SELECTED;
        emit.ev.slot  = srtf_pkg::SLOT_W'(best_r);
        emit.ev.value = best_rem_r;
      end
      ST_END: begin
        emit.req     = end_hit || idle_hit;
        emit.ev.kind = end_hit ? srtf_pkg::EV_END : srtf_pkg::EV_IDLE;
      end
      ST_FLUSH: begin
        emit.flush = 1'b1;
      end
      default: begin
        emit.req = 1'b0;
      end
    endcase
  end

  // Step sequencing.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && in_func == srtf_pkg::FUNC_REPORT) begin
          state_nxt = ST_REP_RD;
        end else if (acc && in_func == srtf_pkg::FUNC_ADVANCE) begin
          state_nxt = ST_FIN_RD;
        end
      end
      ST_REP_RD: state_nxt = ST_REP_EV;
      ST_REP_EV: begin
        if (!stall) state_nxt = ST_FLUSH;
      end
      ST_FIN_RD: begin
        if (running_r) state_nxt = ST_FIN_EV;
        else state_nxt = (n_w == '0) ? ST_SEL : ST_SCAN_RD;
      end
      ST_FIN_EV: begin
        if (!stall) state_nxt = (n_w == '0) ? ST_SEL : ST_SCAN_RD;
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_EV;
      ST_SCAN_EV: begin
        if (!stall) state_nxt = idx_last ? ST_SEL : ST_SCAN_RD;
      end
      ST_SEL: begin
        if (!stall) state_nxt = ST_RUN_RD;
      end
      ST_RUN_RD: begin
        if (run_go) state_nxt = ST_RUN_WR;
        else state_nxt = (n_w == '0) ? ST_END : ST_WAIT_RD;
      end
      ST_RUN_WR: state_nxt = (n_w == '0) ? ST_END : ST_WAIT_RD;
      ST_WAIT_RD: begin
        if (elig) state_nxt = ST_WAIT_WR;
        else if (idx_last) state_nxt = ST_END;
      end
      ST_WAIT_WR: state_nxt = idx_last ? ST_END : ST_WAIT_RD;
      ST_END: begin
        if (!stall) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (oq_stat.flush_ok) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and slot flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      cur_r      <= '0;
      best_vld_r <= 1'b0;
      running_r  <= 1'b0;
      now_r      <= '0;
      arrived_r  <= '0;
      done_r     <= '0;
      loaded_r   <= '0;
    end else begin
      state_r <= state_nxt;

      // Load clears a slot's arrived and done flags, marks it loaded and stops it if it was running.
      if (acc && in_func == srtf_pkg::FUNC_LOAD && slot_ok) begin
        arrived_r[slot_idx] <= 1'b0;
        done_r[slot_idx]    <= 1'b0;
        loaded_r[slot_idx]  <= 1'b1;
        if (running_r && cur_r == slot_idx) begin
          running_r <= 1'b0;
        end
      end
      if (acc) begin
        best_vld_r <= 1'b0;
      end

      // Slot index walks the table in the scan and wait passes.
      if (state_r == ST_FIN_RD || state_r == ST_FIN_EV ||
          state_r == ST_RUN_RD || state_r == ST_RUN_WR) begin
        idx_r <= '0;
      end else if ((state_r == ST_SCAN_EV && !stall && !idx_last) ||
                   (state_r == ST_WAIT_RD && !elig && !idx_last) ||
                   (state_r == ST_WAIT_WR && !idx_last)) begin
        idx_r <= idx_r + IDX_W'(1);
      end

      if (state_r == ST_FIN_EV && fin_hit && !stall) begin
        done_r[cur_r] <= 1'b1;
        running_r     <= 1'b0;
      end

      if (state_r == ST_SCAN_EV && !stall) begin
        if (arr_hit) arrived_r[idx_r] <= 1'b1;
        if (take_best) best_vld_r <= 1'b1;
      end

      if (state_r == ST_SEL && sel_switch && !stall) begin
        cur_r     <= best_r;
        running_r <= 1'b1;
      end

      if (state_r == ST_END && !stall) begin
        now_r <= now_r + TIME_BITS'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (acc) begin
      slot_r <= in_slot;
    end
    if (state_r == ST_FIN_EV) begin
      cur_rem_r <= rd_rem;
    end else if (state_r == ST_SEL && sel_switch && !stall) begin
      cur_rem_r <= best_rem_r;
    end
    if (state_r == ST_SCAN_EV && !stall && take_best) begin
      best_r     <= idx_r;
      best_rem_r <= rd_rem;
    end
  end

endmodule

FILE: hdl/srtf_checker.sv
// Port-level checks of the tick scheduler and their binding to the top level.
`timescale 1ns / 1ps

module srtf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser) &&
                                  $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Reset leaves the block ready and with nothing to send.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

  // A report is the only result of its item.
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == srtf_pkg::EV_REPORT |-> out_tlast)
    else $error("report beat without last mark");

  // Idle and end-of-run events name no slot.
  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == srtf_pkg::EV_IDLE || out_tuser == srtf_pkg::EV_END)
    |-> out_tdata[3:0] == 4'd0 && out_tlast)
    else $error("idle or end event malformed");

endmodule

bind srtf_tick_scheduler srtf_checker u_srtf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
